// ===== rtl/core/geo_point_distance_core_defines.svh =====
// Assertion macros for the point distance core.
`ifndef GEO_POINT_DISTANCE_CORE_DEFINES_SVH
`define GEO_POINT_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gpd_pkg.sv =====
// Constants and the cosine generator for the point distance core.
`timescale 1ns / 1ps
package gpd_pkg;

  localparam int unsigned COS_W = 19;

  localparam logic signed [24:0] LAT_LIMIT = 25'sd9000000;
  localparam logic signed [25:0] LON_LIMIT = 26'sd18000000;

  // quarter turn in Q30
  localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
  // decimeters per 1e-5 degree of arc, Q26
  localparam logic [29:0] DM_PER_UNIT = 30'd746243343;

  // index = (|sum| * (N-1) + IDX_HALF) / (IDX_DIV << IDX_SHIFT)
  localparam int unsigned IDX_HALF    = 9000000;
  localparam int unsigned IDX_SHIFT   = 7;
  localparam int unsigned IDX_DIV     = 140625;
  localparam int unsigned RECIP_SHIFT = 40;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  function automatic logic [63:0] cos_step(input logic [63:0] q);
    cos_step = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
  endfunction

  // Q18 cosine of a Q30 angle, nested Taylor form, evaluated at elaboration
  function automatic logic [COS_W-1:0] cos_q18(input logic [63:0] a);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] r;
    x2 = (a * a) >> 30;
    t  = Q30_ONE;
    t  = cos_step(((x2 * t) >> 30) / 380);
    t  = cos_step(((x2 * t) >> 30) / 306);
    t  = cos_step(((x2 * t) >> 30) / 240);
    t  = cos_step(((x2 * t) >> 30) / 182);
    t  = cos_step(((x2 * t) >> 30) / 132);
    t  = cos_step(((x2 * t) >> 30) / 90);
    t  = cos_step(((x2 * t) >> 30) / 56);
    t  = cos_step(((x2 * t) >> 30) / 30);
    t  = cos_step(((x2 * t) >> 30) / 12);
    t  = cos_step(((x2 * t) >> 30) / 2);
    r  = (t + 64'd2048) >> 12;
    cos_q18 = r[COS_W-1:0];
  endfunction

endpackage

// ===== rtl/core/geo_point_distance_core.sv =====
// Pipelined equirectangular distance between two latitude/longitude points.
`timescale 1ns / 1ps
`include "geo_point_distance_core_defines.svh"

// Takes one coordinate pair per clock while in_ready_o is high and returns its distance
// in decimeters. The 44 register stages are index division (reciprocal multiply plus
// correction), cosine ROM read, east/north offset and squares, one stage per root bit
// (32 stages), root rounding and the final scaling multiply; the result then lands in a
// two-entry output buffer. in_ready_o is registered and drops only when both buffer
// entries hold results, so one transaction per cycle is sustained while the consumer
// keeps up. Out-of-range coordinates give distance 0 with out_of_range_o set.
module geo_point_distance_core
  import gpd_pkg::*;
#(
  parameter int unsigned COS_TABLE_ENTRIES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [24:0] lat_a_i,
  input  logic signed [25:0] lon_a_i,
  input  logic signed [24:0] lat_b_i,
  input  logic signed [25:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [28:0]        distance_dm_o,
  output logic               out_of_range_o
);

  localparam int unsigned IW   = $clog2(COS_TABLE_ENTRIES);
  localparam int unsigned PW   = 27 + IW;
  localparam int unsigned SW   = PW - IDX_SHIFT;
  localparam int unsigned RPW  = SW + 23;
  localparam int unsigned QW   = RPW - RECIP_SHIFT;
  localparam int unsigned QNW  = QW + 1;
  localparam int unsigned QDW  = QW + 18;
  localparam int unsigned NST  = 44;
  localparam int unsigned ST_SQ0  = 10;
  localparam int unsigned ST_LAST = NST - 1;
  localparam logic [22:0] RECIP = 23'((64'd1 << RECIP_SHIFT) / IDX_DIV);

  // cosine ROM
  logic [COS_W-1:0] cos_rom [COS_TABLE_ENTRIES];
  for (genvar gi = 0; gi < COS_TABLE_ENTRIES; gi++) begin : g_rom
    localparam logic [63:0] ANG = (64'(gi) * PIHALF_Q30) / 64'(COS_TABLE_ENTRIES - 1);
    assign cos_rom[gi] = cos_q18(ANG);
  end

  logic en;
  logic [NST-1:0] v_q, oor_q;

  // stage 0 inputs
  logic [25:0] lat_sum, lat_dif, lat_sum_mag, lat_dif_mag;
  logic [26:0] lon_dif, lon_dif_mag;
  logic        oor_in;

  always_comb begin
    lat_sum = {lat_a_i[24], lat_a_i} + {lat_b_i[24], lat_b_i};
    lat_dif = {lat_b_i[24], lat_b_i} - {lat_a_i[24], lat_a_i};
    lon_dif = {lon_b_i[25], lon_b_i} - {lon_a_i[25], lon_a_i};
    lat_sum_mag = lat_sum[25] ? (~lat_sum + 26'd1) : lat_sum;
    lat_dif_mag = lat_dif[25] ? (~lat_dif + 26'd1) : lat_dif;
    lon_dif_mag = lon_dif[26] ? (~lon_dif + 27'd1) : lon_dif;
    oor_in = (lat_a_i > LAT_LIMIT) || (lat_a_i < -LAT_LIMIT) ||
             (lat_b_i > LAT_LIMIT) || (lat_b_i < -LAT_LIMIT) ||
             (lon_a_i > LON_LIMIT) || (lon_a_i < -LON_LIMIT) ||
             (lon_b_i > LON_LIMIT) || (lon_b_i < -LON_LIMIT);
  end

  logic [25:0]      s_q;
  logic [26:0]      dlon_q [6];
  logic [25:0]      dlat_q [7];
  logic [SW-1:0]    psh_q [3];
  logic [RPW-1:0]   rp_q;
  logic [QW-1:0]    qe_q;
  logic [QDW-1:0]   qd_q;
  logic [IW-1:0]    idx_q;
  logic [COS_W-1:0] c_q;
  logic [45:0]      exp_q;
  logic [31:0]      ex_q, ny_q;
  logic [63:0]      ex2_q, ny2_q, sum_q;
  logic [32:0]      r_q;
  logic [63:0]      dmp_q;

  // intermediate terms
  logic [PW-1:0]  p_next;
  logic [SW-1:0]  rem;
  logic [QNW-1:0] qn;
  logic [46:0]    ex_rnd;

  always_comb begin
    p_next = PW'(s_q) * PW'(COS_TABLE_ENTRIES - 1) + PW'(IDX_HALF);
    rem    = psh_q[2] - qd_q[SW-1:0];
    qn     = (rem >= SW'(IDX_DIV)) ? ({1'b0, qe_q} + QNW'(1)) : {1'b0, qe_q};
    ex_rnd = 47'(exp_q) + 47'd2048;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q       <= lat_sum_mag;
      dlon_q[0] <= lon_dif_mag;
      dlat_q[0] <= lat_dif_mag;
      for (int k = 1; k < 6; k++) dlon_q[k] <= dlon_q[k-1];
      for (int k = 1; k < 7; k++) dlat_q[k] <= dlat_q[k-1];
      psh_q[0] <= p_next[PW-1:IDX_SHIFT];
      psh_q[1] <= psh_q[0];
      psh_q[2] <= psh_q[1];
      rp_q     <= RPW'(psh_q[0]) * RPW'(RECIP);
      qe_q     <= rp_q[RPW-1:RECIP_SHIFT];
      qd_q     <= QDW'(rp_q[RPW-1:RECIP_SHIFT]) * QDW'(IDX_DIV);
      idx_q    <= (qn > QNW'(COS_TABLE_ENTRIES - 1)) ? IW'(COS_TABLE_ENTRIES - 1)
                                                      : qn[IW-1:0];
      c_q      <= cos_rom[idx_q];
      exp_q    <= 46'(dlon_q[5]) * 46'(c_q);
      ex_q     <= ex_rnd[43:12];
      ny_q     <= {dlat_q[6], 6'd0};
      ex2_q    <= 64'(ex_q) * 64'(ex_q);
      ny2_q    <= 64'(ny_q) * 64'(ny_q);
      sum_q    <= ex2_q + ny2_q;
    end
  end

  // square root, one result bit per stage
  logic [63:0] sq_rem_q  [32];
  logic [31:0] sq_root_q [32];

  for (genvar gj = 0; gj < 32; gj++) begin : g_sqrt
    localparam int unsigned B = 31 - gj;
    logic [63:0] rem_in, trial;
    logic [31:0] root_in;
    if (gj == 0) begin : g_first
      assign rem_in  = sum_q;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq_rem_q[gj-1];
      assign root_in = sq_root_q[gj-1];
    end
    assign trial = (64'(root_in) << (B + 1)) | (64'd1 << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_in >= trial) begin
          sq_rem_q[gj]  <= rem_in - trial;
          sq_root_q[gj] <= root_in | (32'd1 << B);
        end else begin
          sq_rem_q[gj]  <= rem_in;
          sq_root_q[gj] <= root_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // round to nearest: bump when remainder exceeds the floor root
      r_q   <= (sq_rem_q[31] > 64'(sq_root_q[31])) ? (33'(sq_root_q[31]) + 33'd1)
                                                   : 33'(sq_root_q[31]);
      dmp_q <= 64'(r_q) * 64'(DM_PER_UNIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) oor_q <= {oor_q[NST-2:0], oor_in};
  end

  // two-entry output buffer
  logic [63:0] dm_rnd;
  logic [28:0] dm_new;
  logic        push, pop;
  logic        out_v_q, skid_v_q;
  logic [28:0] out_dm_q, skid_dm_q;
  logic        out_oor_q, skid_oor_q;

  assign en     = !skid_v_q;
  assign dm_rnd = dmp_q + 64'h8000_0000;
  assign dm_new = oor_q[ST_LAST] ? '0 : dm_rnd[60:32];
  assign push   = en && v_q[ST_LAST];
  assign pop    = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || pop) begin
        out_v_q  <= skid_v_q || push;
        skid_v_q <= 1'b0;
      end else if (push) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_dm_q  <= skid_dm_q;
        out_oor_q <= skid_oor_q;
      end else begin
        out_dm_q  <= dm_new;
        out_oor_q <= oor_q[ST_LAST];
      end
    end else if (push) begin
      skid_dm_q  <= dm_new;
      skid_oor_q <= oor_q[ST_LAST];
    end
  end

  assign in_ready_o     = en;
  assign out_valid_o    = out_v_q;
  assign distance_dm_o  = out_dm_q;
  assign out_of_range_o = out_oor_q;

  // largest remainder the last root stage can leave
  logic [63:0] sq_lim;
  assign sq_lim = {31'd0, sq_root_q[31], 1'b0};

  `GPD_ASSERT_NOW(a_oor_zero, out_v_q && out_oor_q, out_dm_q == '0, "out of range with distance")
  `GPD_ASSERT_NOW(a_skid_order, skid_v_q, out_v_q, "skid entry held while output entry empty")
  `GPD_ASSERT_NOW(a_sqrt_rem, v_q[ST_SQ0 + 31], sq_rem_q[31] <= sq_lim, "root remainder too large")
  `GPD_ASSERT_NEXT(a_stall_hold, skid_v_q, $stable(v_q) && $stable(sum_q), "pipeline moved")

endmodule
